// ===== sv/gpb_pkg.sv =====
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared constants and helpers for the glyph pixel blender.
// ----------------------------------------------------------------------------
package gpb_pkg;

	localparam int unsigned COLOUR_W = 32;
	localparam int unsigned RGB_W    = 24;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned COV_W    = 8;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned LEVEL_W  = 4;

	// all ones marks a transparent colour
	localparam logic [COLOUR_W-1:0] TRANSPARENT = '1;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 4'd15;

	localparam logic MODE_MONO = 1'b0;
	localparam logic MODE_GRAY = 1'b1;

	// register index, taken from paddr[3:2]
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FG_COLOUR  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BG_COLOUR  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DRAW_MODE  = 2'd2;

	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// (old*(15-p) + pen*p) / 16, truncated
	function automatic logic [CHAN_W-1:0] blend_chan(
		input logic [CHAN_W-1:0]  old_c,
		input logic [CHAN_W-1:0]  pen_c,
		input logic [LEVEL_W-1:0] p
	);
		logic [LEVEL_W-1:0]        inv_p;
		logic [CHAN_W+LEVEL_W-1:0] sum;
		inv_p = LEVEL_MAX - p;
		// 255*15 fits in 12 bits, so the sum never overflows
		sum = {{LEVEL_W{1'b0}}, old_c} * {{CHAN_W{1'b0}}, inv_p}
			+ {{LEVEL_W{1'b0}}, pen_c} * {{CHAN_W{1'b0}}, p};
		return sum[CHAN_W+LEVEL_W-1:LEVEL_W];
	endfunction

endpackage

// ===== sv/glyph_pixel_blender_core.sv =====
// ----------------------------------------------------------------------------
// glyph_pixel_blender_core
// Turns one glyph bitmap pixel into at most one framebuffer write.
// ----------------------------------------------------------------------------
// One pixel transfer is accepted every clock unless the output stalls, and
// each produces exactly one result: the input register feeds the mono select or
// the 4-bit coverage blend (six 8x4 multiplies, two per channel), whose result
// lands in the output register. Backpressure on the master side stalls both
// stages in place. Registers (APB, byte address): 0x0 fg_colour, 0x4 bg_colour,
// 0x8 draw_mode; write them only while no pixel is in flight. A colour of
// all ones is transparent; a result with write_enable low carries colour 0.
module glyph_pixel_blender_core #(
	parameter int unsigned COORD_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gpb_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [gpb_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [gpb_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	// pixel in
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// origin_x, origin_y, column, row, bitmap_byte, dest_colour, zero pad
	input  logic [((2*COORD_BITS+48+7)/8)*8-1:0] s_axis_tdata,
	// write out
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// write_enable, pixel_x, pixel_y, pixel_colour, zero pad
	output logic [((2*COORD_BITS+36+7)/8)*8-1:0] m_axis_tdata
);

	localparam int unsigned IN_W   = 2*COORD_BITS + 48;
	localparam int unsigned OUT_W  = 2*COORD_BITS + 36;
	localparam int unsigned OUT_PW = ((OUT_W + 7) / 8) * 8;
	localparam int unsigned PIX_W  = COORD_BITS + 1;

	typedef struct packed {
		logic [gpb_pkg::RGB_W-1:0]   dest_colour;
		logic [gpb_pkg::COV_W-1:0]   bitmap_byte;
		logic [gpb_pkg::POS_W-1:0]   row;
		logic [gpb_pkg::POS_W-1:0]   column;
		logic signed [COORD_BITS-1:0] origin_y;
		logic signed [COORD_BITS-1:0] origin_x;
	} pix_in_t;

	typedef struct packed {
		logic [gpb_pkg::COLOUR_W-1:0] pixel_colour;
		logic signed [PIX_W-1:0]      pixel_y;
		logic signed [PIX_W-1:0]      pixel_x;
		logic                         write_enable;
	} pix_out_t;

	// configuration
	logic [gpb_pkg::COLOUR_W-1:0] fg_colour_q;
	logic [gpb_pkg::COLOUR_W-1:0] bg_colour_q;
	logic                         draw_mode_q;
	logic [gpb_pkg::REG_IDX_W-1:0] reg_idx;
	logic                         cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[gpb_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_colour_q  <= gpb_pkg::TRANSPARENT;
			bg_colour_q  <= gpb_pkg::TRANSPARENT;
			draw_mode_q  <= gpb_pkg::MODE_MONO;
		end else if (cfg_wr) begin
			case (reg_idx)
				gpb_pkg::REG_FG_COLOUR:  fg_colour_q  <= pwdata;
				gpb_pkg::REG_BG_COLOUR:  bg_colour_q  <= pwdata;
				gpb_pkg::REG_DRAW_MODE:  draw_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gpb_pkg::REG_FG_COLOUR:  prdata = fg_colour_q;
			gpb_pkg::REG_BG_COLOUR:  prdata = bg_colour_q;
			gpb_pkg::REG_DRAW_MODE:  prdata = {{(gpb_pkg::APB_DATA_W-1){1'b0}}, draw_mode_q};
			default:                 prdata = '0;
		endcase
	end

	// pipeline control
	logic     v_s1, v_s2;
	logic     adv_s1;
	pix_in_t  in_s1;
	pix_out_t res_s2;
	pix_out_t res_d;

	assign adv_s1        = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				v_s1 <= s_axis_tvalid;
			if (adv_s1)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			in_s1 <= pix_in_t'(s_axis_tdata[IN_W-1:0]);
		if (adv_s1 && v_s1)
			res_s2 <= res_d;
	end

	// pixel evaluation
	logic                         fg_opaque, bg_opaque, bit_on;
	logic [2:0]                   bit_sel;
	logic [gpb_pkg::RGB_W-1:0]    old_rgb;
	logic [gpb_pkg::LEVEL_W-1:0]  level;
	logic [gpb_pkg::RGB_W-1:0]    blend_rgb;

	assign fg_opaque = fg_colour_q != gpb_pkg::TRANSPARENT;
	assign bg_opaque = bg_colour_q != gpb_pkg::TRANSPARENT;
	// MSB of the byte is the leftmost pixel
	assign bit_sel   = 3'd7 - in_s1.column[2:0];
	assign bit_on    = in_s1.bitmap_byte[bit_sel];
	assign old_rgb   = bg_opaque ? bg_colour_q[gpb_pkg::RGB_W-1:0] : in_s1.dest_colour;
	assign level     = in_s1.bitmap_byte[gpb_pkg::COV_W-1 -: gpb_pkg::LEVEL_W];

	always_comb begin
		blend_rgb[23:16] = gpb_pkg::blend_chan(old_rgb[23:16], fg_colour_q[23:16], level);
		blend_rgb[15:8]  = gpb_pkg::blend_chan(old_rgb[15:8],  fg_colour_q[15:8],  level);
		blend_rgb[7:0]   = gpb_pkg::blend_chan(old_rgb[7:0],   fg_colour_q[7:0],   level);
	end

	always_comb begin
		res_d.write_enable = 1'b0;
		res_d.pixel_colour = '0;
		res_d.pixel_x = PIX_W'(in_s1.origin_x) + PIX_W'(in_s1.column);
		res_d.pixel_y = PIX_W'(in_s1.origin_y) + PIX_W'(in_s1.row);
		if (draw_mode_q == gpb_pkg::MODE_MONO) begin
			if (bit_on && fg_opaque) begin
				res_d.write_enable = 1'b1;
				res_d.pixel_colour = fg_colour_q;
			end else if (!bit_on && bg_opaque) begin
				res_d.write_enable = 1'b1;
				res_d.pixel_colour = bg_colour_q;
			end
		end else begin
			if (in_s1.bitmap_byte != '0) begin
				if (fg_opaque) begin
					res_d.write_enable = 1'b1;
					res_d.pixel_colour = {8'd0, blend_rgb};
				end
			end else if (bg_opaque) begin
				res_d.write_enable = 1'b1;
				res_d.pixel_colour = bg_colour_q;
			end
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = OUT_PW'(res_s2);

	// input pad bits are ignored
	logic unused_pad;
	assign unused_pad = ^(s_axis_tdata >> IN_W);

endmodule

// ===== sv/gpb_checker.sv =====
// ----------------------------------------------------------------------------
// gpb_checker
// Port-level checks for the glyph pixel blender, bound to the top level.
// ----------------------------------------------------------------------------
module gpb_checker #(
	parameter int unsigned COORD_BITS = 13
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 pready,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [((2*COORD_BITS+36+7)/8)*8-1:0] m_axis_tdata
);

	localparam int unsigned CLR_LO = 2*COORD_BITS + 3;

	logic                         we;
	logic [gpb_pkg::COLOUR_W-1:0] colour;

	assign we     = m_axis_tdata[0];
	assign colour = m_axis_tdata[CLR_LO +: gpb_pkg::COLOUR_W];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a transparent colour never reaches the framebuffer
	a_no_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && we |-> colour != gpb_pkg::TRANSPARENT)
		else $error("transparent colour written");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !we |-> colour == '0)
		else $error("colour not cleared without write");

	// a free output stage always takes the next transfer
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	logic unused_in;
	assign unused_in = s_axis_tvalid;

endmodule

bind glyph_pixel_blender_core gpb_checker #(.COORD_BITS(COORD_BITS)) u_gpb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/glyph_pixel_blender_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_pixel_blender_core_tb
// Self-checking bench for the glyph pixel blender core.
// A short directed table covers the reset state, mono bit select, the gray
// coverage blend and the transparent pen and fill cases. Random pixels
// follow under many register settings. Every result transfer is compared
// field by field with a local prediction of the framebuffer write.
// ----------------------------------------------------------------------------
module glyph_pixel_blender_core_tb;

	localparam int unsigned COORD_BITS  = 13;
	localparam int unsigned IN_DATA_W   = ((2*COORD_BITS+48+7)/8)*8;
	localparam int unsigned OUT_DATA_W  = ((2*COORD_BITS+36+7)/8)*8;
	localparam int unsigned PHASE_ITEMS = 600;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// fields from the lowest bit up: ox, oy, col, row, bits, dest
	typedef struct packed {
		logic [gpb_pkg::RGB_W-1:0] dest;
		logic [gpb_pkg::COV_W-1:0] bits;
		logic [gpb_pkg::POS_W-1:0] row;
		logic [gpb_pkg::POS_W-1:0] col;
		logic [COORD_BITS-1:0]     oy;
		logic [COORD_BITS-1:0]     ox;
	} pixel_t;

	// fields from the lowest bit up: we, x, y, colour
	typedef struct packed {
		logic [gpb_pkg::COLOUR_W-1:0] colour;
		logic [COORD_BITS:0]          y;
		logic [COORD_BITS:0]          x;
		logic                         we;
	} fb_write_t;

	typedef struct packed {
		logic [gpb_pkg::COLOUR_W-1:0] pen;
		logic [gpb_pkg::COLOUR_W-1:0] fill;
		logic                         gray;
	} blend_cfg_t;

	typedef struct packed {
		blend_cfg_t cfg;
		logic       typed;
		fb_write_t  want;
		pixel_t     pix;
	} dir_row_t;

	localparam blend_cfg_t CFG_RESET     =
		{gpb_pkg::TRANSPARENT, gpb_pkg::TRANSPARENT, gpb_pkg::MODE_MONO};
	localparam blend_cfg_t CFG_MONO      = {32'h0012_3456, 32'h00AB_CDEF, gpb_pkg::MODE_MONO};
	localparam blend_cfg_t CFG_MONO_EDGE = {32'hFFFF_FFFE, 32'h0000_0000, gpb_pkg::MODE_MONO};
	localparam blend_cfg_t CFG_GRAY_FILL = {32'h80FF_FFFF, 32'h0000_0000, gpb_pkg::MODE_GRAY};
	localparam blend_cfg_t CFG_GRAY_OVER =
		{32'h0000_0000, gpb_pkg::TRANSPARENT, gpb_pkg::MODE_GRAY};
	localparam blend_cfg_t CFG_GRAY_NOPEN =
		{gpb_pkg::TRANSPARENT, 32'h0020_4060, gpb_pkg::MODE_GRAY};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [gpb_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [gpb_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [gpb_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// origin_x, origin_y, column, row, bitmap_byte, dest_colour, zero pad
	logic [IN_DATA_W-1:0]           s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// write_enable, pixel_x, pixel_y, pixel_colour, zero pad
	logic [OUT_DATA_W-1:0]          m_axis_tdata;

	blend_cfg_t  cur = CFG_RESET;
	fb_write_t   pending_writes[$];
	dir_row_t    dir_rows[$];
	int          send_idle = 35;
	int          recv_idle = 83;
	int          bad_fields = 0;
	int          pixels_sent = 0;
	int          writes_seen = 0;
	int          settings_loaded = 0;
	int unsigned cycles = 0;

	glyph_pixel_blender_core #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// expected framebuffer write for one pixel under the current registers
	function automatic fb_write_t blend_pixel(pixel_t p);
		fb_write_t                 w;
		logic [gpb_pkg::RGB_W-1:0] base;
		logic [3:0]                lvl;
		int                        mix;
		w = '0;
		w.x = {p.ox[COORD_BITS-1], p.ox}
			+ {{(COORD_BITS+1-gpb_pkg::POS_W){1'b0}}, p.col};
		w.y = {p.oy[COORD_BITS-1], p.oy}
			+ {{(COORD_BITS+1-gpb_pkg::POS_W){1'b0}}, p.row};
		if (cur.gray == gpb_pkg::MODE_MONO) begin
			if (p.bits[3'd7 - p.col[2:0]]) begin
				if (cur.pen != gpb_pkg::TRANSPARENT) begin
					w.we = 1'b1;
					w.colour = cur.pen;
				end
			end else if (cur.fill != gpb_pkg::TRANSPARENT) begin
				w.we = 1'b1;
				w.colour = cur.fill;
			end
		end else if (p.bits != '0) begin
			if (cur.pen != gpb_pkg::TRANSPARENT) begin
				base = (cur.fill == gpb_pkg::TRANSPARENT) ? p.dest
					: cur.fill[gpb_pkg::RGB_W-1:0];
				lvl = p.bits[7:4];
				w.we = 1'b1;
				for (int k = 0; k < 3; k++) begin
					mix = (int'(base[8*k +: 8]) * (15 - int'(lvl))
						+ int'(cur.pen[8*k +: 8]) * int'(lvl)) / 16;
					w.colour[8*k +: 8] = mix[7:0];
				end
			end
		end else if (cur.fill != gpb_pkg::TRANSPARENT) begin
			w.we = 1'b1;
			w.colour = cur.fill;
		end
		return w;
	endfunction

	function automatic dir_row_t drow(blend_cfg_t c, bit typed, int ox, int oy, int col,
		int row, int bits, int dest, bit we, int x, int y, logic [31:0] colour);
		dir_row_t r;
		r.cfg = c;
		r.typed = typed;
		r.pix = {(gpb_pkg::RGB_W)'(dest), (gpb_pkg::COV_W)'(bits),
			(gpb_pkg::POS_W)'(row), (gpb_pkg::POS_W)'(col),
			COORD_BITS'(oy), COORD_BITS'(ox)};
		r.want = {colour, (COORD_BITS+1)'(y), (COORD_BITS+1)'(x), we};
		return r;
	endfunction

	function automatic logic [gpb_pkg::COLOUR_W-1:0] rand_colour();
		case ($urandom_range(0, 5))
			0: return gpb_pkg::TRANSPARENT;
			1: return '0;
			2: return 32'h00FF_FFFF;
			3: return 32'hFFFF_FFFE;
			default: return $urandom();
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.ox = COORD_BITS'($urandom());
		p.oy = COORD_BITS'($urandom());
		if ($urandom_range(0, 7) == 0)
			p.ox = $urandom_range(0, 1) ? {1'b1, {(COORD_BITS-1){1'b0}}}
				: {1'b0, {(COORD_BITS-1){1'b1}}};
		if ($urandom_range(0, 7) == 0)
			p.oy = $urandom_range(0, 1) ? {1'b1, {(COORD_BITS-1){1'b0}}}
				: {1'b0, {(COORD_BITS-1){1'b1}}};
		p.col = (gpb_pkg::POS_W)'($urandom());
		p.row = (gpb_pkg::POS_W)'($urandom());
		p.dest = (gpb_pkg::RGB_W)'($urandom());
		case ($urandom_range(0, 5))
			0: p.bits = '0;
			1: p.bits = (gpb_pkg::COV_W)'($urandom_range(1, 15));
			2: p.bits = '1;
			default: p.bits = (gpb_pkg::COV_W)'($urandom());
		endcase
		return p;
	endfunction

	// result side: random backpressure and the field-by-field check
	always @(posedge clk) begin
		fb_write_t got;
		fb_write_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(fb_write_t)-1:0];
			writes_seen <= writes_seen + 1;
			if (pending_writes.size() == 0) begin
				$error("result transfer with nothing pending: %h", got);
				bad_fields++;
			end else begin
				want = pending_writes.pop_front();
				if (got.we !== want.we) begin
					$error("write_enable: expected %0d, got %0d", want.we, got.we);
					bad_fields++;
				end
				if (got.x !== want.x) begin
					$error("pixel_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
					bad_fields++;
				end
				if (got.y !== want.y) begin
					$error("pixel_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
					bad_fields++;
				end
				if (got.colour !== want.colour) begin
					$error("pixel_colour: expected %h, got %h", want.colour, got.colour);
					bad_fields++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	task automatic send_pixel(pixel_t p, bit typed, fb_write_t want);
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'(p);
		do @(posedge clk); while (!s_axis_tready);
		pending_writes.push_back(typed ? want : blend_pixel(p));
		pixels_sent++;
	endtask

	// hold off until every pending write has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// psel stays high between back-to-back writes; the caller lowers it
	task automatic apb_write(logic [gpb_pkg::REG_IDX_W-1:0] idx,
		logic [gpb_pkg::APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic load_settings(blend_cfg_t c);
		drain();
		apb_write(gpb_pkg::REG_FG_COLOUR, c.pen);
		apb_write(gpb_pkg::REG_BG_COLOUR, c.fill);
		apb_write(gpb_pkg::REG_DRAW_MODE, {{(gpb_pkg::APB_DATA_W-1){1'b0}}, c.gray});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur = c;
		settings_loaded++;
	endtask

	initial begin
		blend_cfg_t rc;
		int         next_load;
		int         n_dir;

		// reset state: nothing is drawn, coordinates at both extremes
		dir_rows.push_back(drow(CFG_RESET, 1, -4096, -4096, 0, 0, 'hFF, 0, 0, -4096, -4096, 0));
		dir_rows.push_back(drow(CFG_RESET, 1, 4095, 4095, 255, 255, 'h00, 'hFFFFFF,
			0, 4350, 4350, 0));
		// mono: bit 7 - (col & 7) picks pen or fill
		dir_rows.push_back(drow(CFG_MONO, 1, 0, 0, 0, 0, 'h80, 0, 1, 0, 0, 32'h0012_3456));
		dir_rows.push_back(drow(CFG_MONO, 1, 0, 0, 7, 1, 'h01, 0, 1, 7, 1, 32'h0012_3456));
		dir_rows.push_back(drow(CFG_MONO, 1, 0, 0, 7, 2, 'hFE, 0, 1, 7, 2, 32'h00AB_CDEF));
		dir_rows.push_back(drow(CFG_MONO, 0, -5, 3, 11, 4, 'h10, 'h55AA55, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_MONO, 0, 100, -100, 2, 200, 'h55, 'h0F0F0F, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_MONO, 0, -1, -1, 13, 77, 'h04, 'hABCDEF, 0, 0, 0, 0));
		// mono writes all 32 register bits, zero fill is opaque
		dir_rows.push_back(drow(CFG_MONO_EDGE, 1, 0, 0, 3, 0, 'hFF, 0, 1, 3, 0, 32'hFFFF_FFFE));
		dir_rows.push_back(drow(CFG_MONO_EDGE, 1, 0, 0, 3, 0, 'h00, 'hFFFFFF, 1, 3, 0, 0));
		// gray over an opaque fill; pen upper byte must not leak
		dir_rows.push_back(drow(CFG_GRAY_FILL, 1, 0, 0, 0, 0, 'h00, 'h123456, 1, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_FILL, 0, 40, 50, 1, 2, 'h0F, 'h123456, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_FILL, 0, 40, 50, 3, 4, 'hFF, 'h123456, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_FILL, 0, 40, 50, 5, 6, 'h80, 'h123456, 0, 0, 0, 0));
		// transparent fill: blend over the destination
		dir_rows.push_back(drow(CFG_GRAY_OVER, 1, 0, 0, 0, 0, 'h00, 'h123456, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_OVER, 0, -7, 9, 8, 9, 'h01, 'hFFFFFF, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_OVER, 0, -7, 9, 10, 11, 'hF0, 'h123456, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_OVER, 0, -7, 9, 12, 13, 'hFF, 'h000000, 0, 0, 0, 0));
		// transparent pen: only zero coverage draws the fill
		dir_rows.push_back(drow(CFG_GRAY_NOPEN, 1, 0, 0, 0, 0, 'h00, 'h111111,
			1, 0, 0, 32'h0020_4060));
		dir_rows.push_back(drow(CFG_GRAY_NOPEN, 1, 0, 0, 0, 0, 'hFF, 'h111111, 0, 0, 0, 0));
		dir_rows.push_back(drow(CFG_GRAY_NOPEN, 1, 0, 0, 0, 0, 'h10, 'h111111, 0, 0, 0, 0));
		n_dir = dir_rows.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg != cur)
				load_settings(dir_rows[i].cfg);
			send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 35; recv_idle = 83; end
				1: begin send_idle = 83; recv_idle = 35; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			next_load = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == next_load) begin
					rc.pen = rand_colour();
					rc.fill = rand_colour();
					rc.gray = 1'($urandom_range(0, 1));
					load_settings(rc);
					next_load = i + $urandom_range(60, 140);
				end else if ($urandom_range(0, 199) == 0) begin
					drain();
				end
				send_pixel(rand_pixel(), 1'b0, '0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d pixel transfers (%0d from the directed table)",
			pixels_sent, n_dir);
		$display("under %0d register settings; %0d write transfers, %0d field mismatches",
			settings_loaded, writes_seen, bad_fields);
		if (bad_fields == 0 && pending_writes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gpb_pkg.sv
sv/glyph_pixel_blender_core.sv
sv/gpb_checker.sv
tb/sv/glyph_pixel_blender_core_tb.sv
